@@ rtl/core/reload_down_counter_timer_macros.svh @@
// Assertion macros shared by the timer's checker.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef RELOAD_DOWN_COUNTER_TIMER_MACROS_SVH
`define RELOAD_DOWN_COUNTER_TIMER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RDCT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RDCT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timer assertion failed");

`endif

@@ rtl/core/rdct_pkg.sv @@
// Shared types and constants for the reload down-counter timer.
// No dependencies; used by every module of the block.
package rdct_pkg;

   localparam int CountWidth = 16;
   localparam int ByteWidth  = 8;

   localparam logic [CountWidth-1:0] COUNT_ALL_ONES = 16'hFFFF;
   localparam logic [CountWidth-1:0] COUNT_ZERO     = 16'h0000;

   typedef enum logic [2:0] {
      ACT_TICK       = 3'd0,
      ACT_WRITE_LOW  = 3'd1,
      ACT_WRITE_HIGH = 3'd2,
      ACT_RESTART    = 3'd3,
      ACT_CLEAR_ALL  = 3'd4
   } action_type;

   typedef struct packed {
      logic [2:0]           action;
      logic [ByteWidth-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [CountWidth-1:0] count_value;
      logic                  hit_zero;
      logic                  low_byte_zero;
      logic                  hit_half;
      logic                  irq_pending;
      logic                  running;
   } rsp_type;

endpackage

@@ rtl/core/rdct_in_stage.sv @@
// Input register stage of the timer: captures one request transaction.
// Depends on rdct_pkg.
module rdct_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rdct_pkg::req_type in_item,
   output logic             out_valid,
   input  logic             out_ready,
   output rdct_pkg::req_type out_item
);
   import rdct_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

@@ rtl/core/rdct_core.sv @@
// Timer state and its update for one action per cycle in which advance is high.
// Depends on rdct_pkg.
module rdct_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic              csr_mode,
   input  logic              advance,
   input  rdct_pkg::req_type item,
   output rdct_pkg::rsp_type result
);
   import rdct_pkg::*;

   logic [CountWidth-1:0] reload_ff, reload_in;
   logic [CountWidth-1:0] counter_ff, counter_in;
   logic                  counting_ff, counting_in;
   logic                  half_seen_ff, half_seen_in;
   logic                  irq_ff, irq_in;
   logic                  p_zero_ff, p_zero_in;
   logic                  p_low_ff, p_low_in;
   logic                  p_half_ff, p_half_in;
   logic                  mode_ff;

   logic [CountWidth-1:0] dec;
   logic [CountWidth-1:0] target;
   logic [CountWidth-1:0] half_level;

   assign dec        = counter_ff - {{(CountWidth-1){1'b0}}, 1'b1};
   assign target     = mode_ff ? reload_ff : COUNT_ALL_ONES;
   assign half_level = {1'b0, reload_ff[CountWidth-1:1]};

   always_comb begin
      reload_in    = reload_ff;
      counter_in   = counter_ff;
      counting_in  = counting_ff;
      half_seen_in = half_seen_ff;
      irq_in       = irq_ff;
      p_zero_in    = p_zero_ff;
      p_low_in     = p_low_ff;
      p_half_in    = p_half_ff;
      case (action_type'(item.action))
         ACT_TICK: begin
            p_zero_in = 1'b0;
            p_low_in  = 1'b0;
            p_half_in = 1'b0;
            if (counting_ff) begin
               counter_in = dec;
               p_zero_in  = (dec == COUNT_ZERO);
               p_low_in   = (dec[ByteWidth-1:0] == COUNT_ZERO[ByteWidth-1:0]);
               if (!half_seen_ff && dec <= half_level) begin
                  p_half_in    = 1'b1;
                  half_seen_in = 1'b1;
               end
               // Underflow: raise the request and reload within the same tick.
               if (dec == COUNT_ZERO) begin
                  irq_in       = 1'b1;
                  counter_in   = target;
                  half_seen_in = 1'b0;
               end
            end
         end
         ACT_WRITE_LOW, ACT_WRITE_HIGH: begin
            if (action_type'(item.action) == ACT_WRITE_LOW) begin
               reload_in   = {reload_ff[CountWidth-1:ByteWidth], item.data_byte};
               counting_in = 1'b0;
            end else begin
               reload_in   = {item.data_byte, reload_ff[ByteWidth-1:0]};
               counting_in = 1'b1;
            end
            counter_in   = reload_in;
            half_seen_in = 1'b0;
            p_zero_in    = 1'b0;
            p_low_in     = 1'b0;
            p_half_in    = 1'b0;
         end
         ACT_RESTART: begin
            counter_in   = target;
            counting_in  = 1'b0;
            half_seen_in = 1'b0;
            p_zero_in    = 1'b0;
            p_low_in     = 1'b0;
            p_half_in    = 1'b0;
         end
         ACT_CLEAR_ALL: begin
            reload_in    = COUNT_ZERO;
            counter_in   = COUNT_ZERO;
            counting_in  = 1'b0;
            half_seen_in = 1'b0;
            irq_in       = 1'b0;
            p_zero_in    = 1'b0;
            p_low_in     = 1'b0;
            p_half_in    = 1'b0;
         end
         default: begin
            // Unused codes leave everything, held pulses included, as it is.
         end
      endcase
   end

   // The result reflects the state as it will be after this transaction.
   assign result.count_value   = counter_in;
   assign result.hit_zero      = p_zero_in;
   assign result.low_byte_zero = p_low_in;
   assign result.hit_half      = p_half_in;
   assign result.irq_pending   = irq_in;
   assign result.running       = counting_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff    <= COUNT_ZERO;
         counter_ff   <= COUNT_ZERO;
         counting_ff  <= 1'b0;
         half_seen_ff <= 1'b0;
         irq_ff       <= 1'b0;
         p_zero_ff    <= 1'b0;
         p_low_ff     <= 1'b0;
         p_half_ff    <= 1'b0;
         mode_ff      <= 1'b1;
      end else begin
         if (advance) begin
            reload_ff    <= reload_in;
            counter_ff   <= counter_in;
            counting_ff  <= counting_in;
            half_seen_ff <= half_seen_in;
            irq_ff       <= irq_in;
            p_zero_ff    <= p_zero_in;
            p_low_ff     <= p_low_in;
            p_half_ff    <= p_half_in;
         end
         if (csr_write) begin
            mode_ff <= csr_mode;
         end
      end
   end

endmodule

@@ rtl/core/rdct_out_stage.sv @@
// Result register stage of the timer: holds one response transaction.
// Depends on rdct_pkg.
module rdct_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rdct_pkg::rsp_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output rdct_pkg::rsp_type out_item
);
   import rdct_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type item_ff, item_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

@@ rtl/core/reload_down_counter_timer.sv @@
// 16-bit reload down-counter timer. Each request transaction carries one
// action (tick, reload low-byte write, reload high-byte write, restart, clear
// all) and yields exactly one response transaction with the counter value,
// the zero, low-byte-zero and half pulses, the sticky interrupt request and
// the running flag. One transaction is accepted every cycle while the response
// side does not stall; a request passes through the request register and then
// the result register, and the whole state update lies between the two.
// Ready runs back combinationally from the response side through both
// registers. The mode register on the csr_ port is always ready.
module reload_down_counter_timer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [2:0]                      req_action,
   input  logic [rdct_pkg::ByteWidth-1:0]  req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rdct_pkg::CountWidth-1:0] rsp_count_value,
   output logic                            rsp_hit_zero,
   output logic                            rsp_low_byte_zero,
   output logic                            rsp_hit_half,
   output logic                            rsp_irq_pending,
   output logic                            rsp_running,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_reload_from_value_mode
);
   import rdct_pkg::*;

   req_type req_item;
   req_type staged_item;
   rsp_type core_result;
   rsp_type rsp_item;
   logic    staged_valid;
   logic    result_ready;

   assign req_item.action    = req_action;
   assign req_item.data_byte = req_data_byte;
   assign csr_ready          = 1'b1;

   rdct_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .out_valid (staged_valid),
      .out_ready (result_ready),
      .out_item  (staged_item)
   );

   rdct_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_mode  (csr_reload_from_value_mode),
      .advance   (staged_valid && result_ready),
      .item      (staged_item),
      .result    (core_result)
   );

   rdct_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (staged_valid),
      .in_ready  (result_ready),
      .in_item   (core_result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_item)
   );

   assign rsp_count_value   = rsp_item.count_value;
   assign rsp_hit_zero      = rsp_item.hit_zero;
   assign rsp_low_byte_zero = rsp_item.low_byte_zero;
   assign rsp_hit_half      = rsp_item.hit_half;
   assign rsp_irq_pending   = rsp_item.irq_pending;
   assign rsp_running       = rsp_item.running;

endmodule

@@ rtl/core/rdct_checker.sv @@
// Port-level checker for the reload down-counter timer, bound to the top level.
// Depends on rdct_pkg and reload_down_counter_timer_macros.svh.
`include "reload_down_counter_timer_macros.svh"

module rdct_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [rdct_pkg::CountWidth-1:0] rsp_count_value,
   input logic                            rsp_hit_zero,
   input logic                            rsp_low_byte_zero,
   input logic                            rsp_irq_pending,
   input logic                            rsp_running
);
   import rdct_pkg::*;

   // A stalled response transaction keeps its counter value.
   `RDCT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_count_value))

   // An underflow always leaves the interrupt request set.
   `RDCT_ASSERT_IMPL(a_zero_sets_irq, rsp_valid && rsp_hit_zero, rsp_irq_pending)

   // Reaching zero implies the low byte reached zero too.
   `RDCT_ASSERT_IMPL(a_zero_has_low, rsp_valid && rsp_hit_zero, rsp_low_byte_zero)

   // Pulses only come from ticks taken while counting, which keep it running.
   `RDCT_ASSERT_IMPL(a_pulse_running, rsp_valid && rsp_low_byte_zero, rsp_running)

endmodule

bind reload_down_counter_timer rdct_checker u_rdct_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_count_value   (rsp_count_value),
   .rsp_hit_zero      (rsp_hit_zero),
   .rsp_low_byte_zero (rsp_low_byte_zero),
   .rsp_irq_pending   (rsp_irq_pending),
   .rsp_running       (rsp_running)
);

@@ sim/tb_top.sv @@
// Self-checking testbench for the reload down-counter timer.
// It depends on rdct_pkg and reload_down_counter_timer. It predicts every response
// from its own timer model and checks each response field against that prediction.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rdct_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 8;
   localparam int RandomItemsPerPhase = 300;

   // These action codes are not defined in the package. The block must ignore them.
   localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] ACT_UNUSED_MID   = 3'd6;
   localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [2:0]            req_action = '0;
   logic [ByteWidth-1:0]  req_data_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CountWidth-1:0] rsp_count_value;
   logic                  rsp_hit_zero;
   logic                  rsp_low_byte_zero;
   logic                  rsp_hit_half;
   logic                  rsp_irq_pending;
   logic                  rsp_running;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_reload_from_value_mode = 1'b0;

   // Timer model state.
   logic [CountWidth-1:0] tmr_reload;
   logic [CountWidth-1:0] tmr_count;
   logic                  tmr_counting;
   logic                  tmr_half_seen;
   logic                  tmr_irq;
   logic                  tmr_pulse_zero;
   logic                  tmr_pulse_low;
   logic                  tmr_pulse_half;
   logic                  tmr_reload_mode;

   rsp_type pending_rsps[$];
   int      errors = 0;
   int      cycles = 0;
   int      items_sent = 0;
   int      send_idle_pct = 16;
   int      recv_idle_pct = 86;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   reload_down_counter_timer dut (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_ready                  (req_ready),
      .req_action                 (req_action),
      .req_data_byte              (req_data_byte),
      .rsp_valid                  (rsp_valid),
      .rsp_ready                  (rsp_ready),
      .rsp_count_value            (rsp_count_value),
      .rsp_hit_zero               (rsp_hit_zero),
      .rsp_low_byte_zero          (rsp_low_byte_zero),
      .rsp_hit_half               (rsp_hit_half),
      .rsp_irq_pending            (rsp_irq_pending),
      .rsp_running                (rsp_running),
      .csr_valid                  (csr_valid),
      .csr_ready                  (csr_ready),
      .csr_reload_from_value_mode (csr_reload_from_value_mode)
   );

   function automatic void timer_reset();
      tmr_reload      = COUNT_ZERO;
      tmr_count       = COUNT_ZERO;
      tmr_counting    = 1'b0;
      tmr_half_seen   = 1'b0;
      tmr_irq         = 1'b0;
      tmr_pulse_zero  = 1'b0;
      tmr_pulse_low   = 1'b0;
      tmr_pulse_half  = 1'b0;
      tmr_reload_mode = 1'b1;
   endfunction

   function automatic void clear_pulses();
      tmr_pulse_zero = 1'b0;
      tmr_pulse_low  = 1'b0;
      tmr_pulse_half = 1'b0;
   endfunction

   // This function applies one action to the timer model and returns the response for it.
   function automatic rsp_type timer_step(input logic [2:0] act,
                                          input logic [ByteWidth-1:0] data);
      rsp_type r;
      case (act)
         ACT_TICK: begin
            clear_pulses();
            if (tmr_counting) begin
               tmr_count      = tmr_count - 16'd1;
               tmr_pulse_zero = (tmr_count == COUNT_ZERO);
               tmr_pulse_low  = (tmr_count[7:0] == 8'h00);
               if (!tmr_half_seen && tmr_count <= (tmr_reload >> 1)) begin
                  tmr_pulse_half = 1'b1;
                  tmr_half_seen  = 1'b1;
               end
               if (tmr_count == COUNT_ZERO) begin
                  tmr_irq       = 1'b1;
                  tmr_count     = tmr_reload_mode ? tmr_reload : COUNT_ALL_ONES;
                  tmr_half_seen = 1'b0;
               end
            end
         end
         ACT_WRITE_LOW, ACT_WRITE_HIGH: begin
            if (act == ACT_WRITE_LOW)
               tmr_reload[7:0] = data;
            else
               tmr_reload[15:8] = data;
            tmr_count     = tmr_reload;
            tmr_counting  = (act == ACT_WRITE_HIGH);
            tmr_half_seen = 1'b0;
            clear_pulses();
         end
         ACT_RESTART: begin
            tmr_count     = tmr_reload_mode ? tmr_reload : COUNT_ALL_ONES;
            tmr_half_seen = 1'b0;
            tmr_counting  = 1'b0;
            clear_pulses();
         end
         ACT_CLEAR_ALL: begin
            tmr_reload    = COUNT_ZERO;
            tmr_count     = COUNT_ZERO;
            tmr_counting  = 1'b0;
            tmr_half_seen = 1'b0;
            tmr_irq       = 1'b0;
            clear_pulses();
         end
         default: begin
         end
      endcase
      r.count_value   = tmr_count;
      r.hit_zero      = tmr_pulse_zero;
      r.low_byte_zero = tmr_pulse_low;
      r.hit_half      = tmr_pulse_half;
      r.irq_pending   = tmr_irq;
      r.running       = tmr_counting;
      return r;
   endfunction

   // Valid stays high after acceptance. The next call either holds it high for
   // back-to-back transactions or lowers it for an idle gap.
   task automatic send_item(input logic [2:0] act, input logic [ByteWidth-1:0] data);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      pending_rsps.push_back(timer_step(act, data));
      if (act <= ACT_CLEAR_ALL)
         items_sent++;
   endtask

   task automatic tick_n(input int n);
      repeat (n) send_item(ACT_TICK, ByteWidth'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      drain();
      csr_valid                  <= 1'b1;
      csr_reload_from_value_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid       <= 1'b0;
      tmr_reload_mode = mode;
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      cycles++;
      if (cycles > CycleLimit) begin
         $display("%0t: timeout with %0d responses outstanding", $time, pending_rsps.size());
         $display("== FAIL ==");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_count_value, rsp_hit_zero, rsp_low_byte_zero, rsp_hit_half,
                rsp_irq_pending, rsp_running};
         if (pending_rsps.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
         end else begin
            want = pending_rsps.pop_front();
            compare_field("count_value", want.count_value, got.count_value);
            compare_field("hit_zero", 16'(want.hit_zero), 16'(got.hit_zero));
            compare_field("low_byte_zero", 16'(want.low_byte_zero),
                          16'(got.low_byte_zero));
            compare_field("hit_half", 16'(want.hit_half), 16'(got.hit_half));
            compare_field("irq_pending", 16'(want.irq_pending), 16'(got.irq_pending));
            compare_field("running", 16'(want.running), 16'(got.running));
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic test_stopped_and_unused_codes();
      send_item(ACT_TICK, 8'h00);
      send_item(ACT_UNUSED_FIRST, 8'hFF);
      send_item(ACT_UNUSED_LAST, 8'h00);
      send_item(ACT_WRITE_LOW, 8'hFF);
      send_item(ACT_WRITE_HIGH, 8'hFF);
      send_item(ACT_TICK, 8'hFF);
      send_item(ACT_RESTART, 8'h00);
      send_item(ACT_TICK, 8'h55);
   endtask

   task automatic test_underflow_and_wrap();
      send_item(ACT_CLEAR_ALL, 8'hAA);
      send_item(ACT_WRITE_LOW, 8'h04);
      send_item(ACT_WRITE_HIGH, 8'h00);
      // The count runs through the half point to zero and then reloads.
      tick_n(4);
      // An unused code must report the pulses of the underflow tick unchanged.
      send_item(ACT_UNUSED_MID, 8'h3C);
      send_item(ACT_TICK, 8'hC3);
      // A zero count that is ticked wraps to all ones and gives no zero pulse.
      send_item(ACT_CLEAR_ALL, 8'h00);
      send_item(ACT_WRITE_LOW, 8'h00);
      send_item(ACT_WRITE_HIGH, 8'h00);
      send_item(ACT_TICK, 8'h00);
   endtask

   task automatic test_all_ones_reload_mode();
      write_mode(1'b0);
      send_item(ACT_WRITE_LOW, 8'h02);
      send_item(ACT_WRITE_HIGH, 8'h00);
      tick_n(2);
      send_item(ACT_RESTART, 8'hFF);
      write_mode(1'b1);
      send_item(ACT_RESTART, 8'h00);
   endtask

   // Most sequences program a reload value, half of them below 21, start the
   // counter and tick it through possible underflows. The rest are random actions as noise.
   task automatic test_random(input int count);
      int                   first;
      int                   ticks;
      logic [ByteWidth-1:0] lo;
      logic [ByteWidth-1:0] hi;
      first = items_sent;
      while (items_sent - first < count) begin
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 3))
               0, 1: begin
                  lo = ByteWidth'($urandom_range(0, 20));
                  hi = 8'h00;
               end
               2: begin
                  lo = ByteWidth'($urandom_range(0, 20));
                  hi = 8'h01;
               end
               default: begin
                  lo = ByteWidth'($urandom);
                  hi = ByteWidth'($urandom);
               end
            endcase
            send_item(ACT_WRITE_LOW, lo);
            send_item(ACT_WRITE_HIGH, hi);
            ticks = $urandom_range(1, 45);
            repeat (ticks) begin
               if ($urandom_range(0, 29) == 0)
                  send_item(ACT_RESTART, ByteWidth'($urandom));
               else
                  send_item(ACT_TICK, ByteWidth'($urandom));
            end
         end else begin
            send_item(3'($urandom_range(0, 7)), ByteWidth'($urandom));
         end
      end
   endtask

   initial begin
      timer_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_mode(1'b1);
      test_stopped_and_unused_codes();
      test_underflow_and_wrap();
      test_all_ones_reload_mode();
      test_random(RandomItemsPerPhase);
      write_mode(1'b0);
      send_idle_pct = 86;
      recv_idle_pct = 16;
      test_random(RandomItemsPerPhase);
      write_mode(1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(RandomItemsPerPhase);
      drain();
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0 && pending_rsps.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
